// ===== design/lpsm_pkg.sv =====
// lpsm_pkg: shared constants, codes and reset values of the link statistics monitor
// no dependencies; imported by the interfaces and every module of the block
package lpsm_pkg;

    // default widths of the configurable fields
    localparam int TIME_BITS_DEF  = 48;
    localparam int SEQ_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    // fixed field widths
    localparam int OPCODE_W   = 2;
    localparam int KIND_W     = 2;
    localparam int HEADER_W   = 16;
    localparam int TARGET_W   = 16;
    localparam int FBYTES_W   = 8;
    localparam int LOST_W     = 32;
    localparam int BYTES_W    = 24;
    localparam int RSSI_W     = 8;
    localparam int RSSI_SUM_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // depth of the queue between front and back end, a power of two
    localparam int FIFO_DEPTH = 2;

    // register reset values
    localparam logic [TARGET_W-1:0] TARGET_RESET = 16'd1000;
    localparam logic [HEADER_W-1:0] MAGIC_RESET  = 16'hAA55;
    localparam logic [FBYTES_W-1:0] FBYTES_RESET = 8'd16;

    // signal strength statistics at session start
    localparam logic signed [RSSI_W-1:0] RSSI_MIN_RESET = 8'sd0;
    localparam logic signed [RSSI_W-1:0] RSSI_MAX_RESET = -8'sd127;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PACKET = 2'd0,
        OP_START  = 2'd1,
        OP_END    = 2'd2
    } opcode_t;

    typedef enum logic [KIND_W-1:0] {
        RPT_RUNNING  = 2'd0,
        RPT_COMPLETE = 2'd1,
        RPT_PARTIAL  = 2'd2
    } report_kind_t;

    // what the back end does with a queued command
    typedef enum logic [1:0] {
        CMD_SNAPSHOT = 2'd0,
        CMD_CLEAR    = 2'd1,
        CMD_PACKET   = 2'd2
    } cmd_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_MAGIC  = 2'd1,
        CFG_FBYTES = 2'd2
    } cfg_index_t;

endpackage

// ===== design/lpsm_ifs.sv =====
// lpsm_ifs: valid/ready channel interfaces for events, reports and register writes
// depends on lpsm_pkg
interface lpsm_event_if import lpsm_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int SEQ_BITS  = SEQ_BITS_DEF
) ();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [TIME_BITS-1:0]       now_us;
    logic [HEADER_W-1:0]        frame_header;
    logic [SEQ_BITS-1:0]        sequence_req;
    logic [TIME_BITS-1:0]       sent_time_us;
    logic signed [RSSI_W-1:0]   signal_dbm;

    modport source (
        output valid, opcode, now_us, frame_header, sequence_req, sent_time_us, signal_dbm,
        input  ready
    );
    modport sink (
        input  valid, opcode, now_us, frame_header, sequence_req, sent_time_us, signal_dbm,
        output ready
    );
endinterface

interface lpsm_report_if import lpsm_pkg::*; #(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic [KIND_W-1:0]              report_kind;
    logic [COUNT_BITS-1:0]          packets_seen;
    logic [LOST_W-1:0]              packets_lost;
    logic [BYTES_W-1:0]             bytes_seen;
    logic [TIME_BITS-1:0]           duration_us;
    logic [TIME_BITS-1:0]           jitter_total_us;
    logic [TIME_BITS-1:0]           latency_total_us;
    logic signed [RSSI_W-1:0]       signal_low;
    logic signed [RSSI_W-1:0]       signal_high;
    logic signed [RSSI_SUM_W-1:0]   signal_total;

    modport source (
        output valid, accepted, report_kind, packets_seen, packets_lost, bytes_seen,
               duration_us, jitter_total_us, latency_total_us, signal_low, signal_high,
               signal_total,
        input  ready
    );
    modport sink (
        input  valid, accepted, report_kind, packets_seen, packets_lost, bytes_seen,
               duration_us, jitter_total_us, latency_total_us, signal_low, signal_high,
               signal_total,
        output ready
    );
endinterface

interface lpsm_cfg_if import lpsm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/lpsm_front.sv =====
// lpsm_front: accepts events, checks headers, tracks session timing and sequence state
// depends on lpsm_pkg and lpsm_event_if; feeds commands into lpsm_fifo
module lpsm_front import lpsm_pkg::*; #(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int SEQ_BITS   = SEQ_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter type cmd_t     = logic
) (
    input  logic                clk,
    input  logic                rst_n,
    lpsm_event_if.sink          event_ch,
    input  logic [TARGET_W-1:0] target_packets,
    input  logic [HEADER_W-1:0] header_magic,
    output logic                push_valid,
    input  logic                push_ready,
    output cmd_t                push_cmd
);

    localparam int CMP_W = (COUNT_BITS > TARGET_W) ? COUNT_BITS : TARGET_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [TIME_BITS-1:0]  session_start_reg, session_start_next;
    logic [TIME_BITS-1:0]  last_arrival_reg, last_arrival_next;
    logic [SEQ_BITS-1:0]   last_sequence_reg, last_sequence_next;
    logic [COUNT_BITS-1:0] packet_count_reg, packet_count_next;

    logic                  take;
    logic                  header_ok;
    logic                  first_packet;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  complete;
    logic [TIME_BITS-1:0]  arrival_diff;
    logic [TIME_BITS-1:0]  latency_diff;
    logic [SEQ_BITS:0]     seq_delta;
    logic                  gap_positive;

    assign take           = event_ch.valid && push_ready;
    assign event_ch.ready = push_ready;
    assign push_valid     = event_ch.valid;

    assign header_ok    = (event_ch.frame_header == header_magic);
    assign first_packet = (packet_count_reg == '0);
    assign count_inc    = (packet_count_reg == COUNT_MAX) ? packet_count_reg
                                                          : packet_count_reg + 1'b1;
    assign complete     = (CMP_W'(count_inc) >= CMP_W'(target_packets));

    assign arrival_diff = (event_ch.now_us >= last_arrival_reg)
                        ? event_ch.now_us - last_arrival_reg
                        : last_arrival_reg - event_ch.now_us;
    assign latency_diff = (event_ch.now_us >= event_ch.sent_time_us)
                        ? event_ch.now_us - event_ch.sent_time_us
                        : event_ch.sent_time_us - event_ch.now_us;

    // new minus previous minus one, signed; lost only when strictly positive
    assign seq_delta    = {1'b0, event_ch.sequence_req} - {1'b0, last_sequence_reg}
                        - {{SEQ_BITS{1'b0}}, 1'b1};
    assign gap_positive = !seq_delta[SEQ_BITS] && (seq_delta != '0);

    always_comb
    begin
        push_cmd              = '0;
        push_cmd.kind         = CMD_SNAPSHOT;
        push_cmd.accepted     = 1'b0;
        push_cmd.report_kind  = RPT_RUNNING;
        push_cmd.packets_seen = packet_count_reg;
        push_cmd.duration     = event_ch.now_us - session_start_reg;
        push_cmd.jitter_inc   = '0;
        push_cmd.latency_inc  = '0;
        push_cmd.gap          = '0;
        push_cmd.rssi         = event_ch.signal_dbm;

        session_start_next = session_start_reg;
        last_arrival_next  = last_arrival_reg;
        last_sequence_next = last_sequence_reg;
        packet_count_next  = packet_count_reg;

        unique case (event_ch.opcode)
            OP_START:
            begin
                push_cmd.kind         = CMD_CLEAR;
                push_cmd.packets_seen = '0;
                push_cmd.duration     = '0;
                session_start_next    = event_ch.now_us;
                last_arrival_next     = '0;
                last_sequence_next    = '0;
                packet_count_next     = '0;
            end
            OP_END:
            begin
                push_cmd.report_kind = first_packet ? RPT_RUNNING : RPT_PARTIAL;
            end
            OP_PACKET:
            begin
                if (header_ok)
                begin
                    push_cmd.kind         = CMD_PACKET;
                    push_cmd.accepted     = 1'b1;
                    push_cmd.packets_seen = count_inc;
                    push_cmd.report_kind  = complete ? RPT_COMPLETE : RPT_RUNNING;
                    push_cmd.jitter_inc   = first_packet ? '0 : arrival_diff;
                    push_cmd.latency_inc  = (event_ch.sent_time_us == '0) ? '0 : latency_diff;
                    push_cmd.gap          = (!first_packet && gap_positive)
                                          ? seq_delta[SEQ_BITS-1:0] : '0;
                    last_arrival_next     = event_ch.now_us;
                    last_sequence_next    = event_ch.sequence_req;
                    packet_count_next     = count_inc;
                    if (complete)
                    begin
                        session_start_next = event_ch.now_us;
                        last_arrival_next  = '0;
                        last_sequence_next = '0;
                        packet_count_next  = '0;
                    end
                end
            end
            default:
            begin
                push_cmd.kind = CMD_SNAPSHOT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_start_reg <= '0;
            last_arrival_reg  <= '0;
            last_sequence_reg <= '0;
            packet_count_reg  <= '0;
        end
        else if (take)
        begin
            session_start_reg <= session_start_next;
            last_arrival_reg  <= last_arrival_next;
            last_sequence_reg <= last_sequence_next;
            packet_count_reg  <= packet_count_next;
        end
    end

endmodule

// ===== design/lpsm_fifo.sv =====
// lpsm_fifo: short command queue that decouples the front end from the back end
// depends on lpsm_pkg for the default depth
module lpsm_fifo import lpsm_pkg::*; #(
    parameter int  DEPTH   = FIFO_DEPTH,
    parameter type entry_t = logic
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output entry_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/lpsm_back.sv =====
// lpsm_back: saturating statistics accumulators and the registered report output
// depends on lpsm_pkg and lpsm_report_if; takes commands from lpsm_fifo
module lpsm_back import lpsm_pkg::*; #(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter type cmd_t     = logic
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  cmd_t                pop_cmd,
    input  logic [FBYTES_W-1:0] frame_bytes,
    lpsm_report_if.source       report_ch
);

    localparam logic signed [RSSI_SUM_W-1:0] RSSI_SUM_MAX = {1'b0, {(RSSI_SUM_W-1){1'b1}}};
    localparam logic signed [RSSI_SUM_W-1:0] RSSI_SUM_MIN = {1'b1, {(RSSI_SUM_W-1){1'b0}}};

    // statistics
    logic [LOST_W-1:0]            lost_reg, lost_next;
    logic [BYTES_W-1:0]           bytes_reg, bytes_next;
    logic [TIME_BITS-1:0]         jitter_reg, jitter_next;
    logic [TIME_BITS-1:0]         latency_reg, latency_next;
    logic signed [RSSI_SUM_W-1:0] rssi_sum_reg, rssi_sum_next;
    logic signed [RSSI_W-1:0]     rssi_min_reg, rssi_min_next;
    logic signed [RSSI_W-1:0]     rssi_max_reg, rssi_max_next;

    // values after the packet is applied
    logic [TIME_BITS:0]           jitter_wide;
    logic [TIME_BITS:0]           latency_wide;
    logic [LOST_W:0]              lost_wide;
    logic [BYTES_W:0]             bytes_wide;
    logic signed [RSSI_SUM_W:0]   rssi_wide;
    logic [TIME_BITS-1:0]         jitter_upd;
    logic [TIME_BITS-1:0]         latency_upd;
    logic [LOST_W-1:0]            lost_upd;
    logic [BYTES_W-1:0]           bytes_upd;
    logic signed [RSSI_SUM_W-1:0] rssi_sum_upd;
    logic signed [RSSI_W-1:0]     rssi_min_upd;
    logic signed [RSSI_W-1:0]     rssi_max_upd;

    // what the report shows
    logic [TIME_BITS-1:0]         show_jitter;
    logic [TIME_BITS-1:0]         show_latency;
    logic [LOST_W-1:0]            show_lost;
    logic [BYTES_W-1:0]           show_bytes;
    logic signed [RSSI_SUM_W-1:0] show_rssi_sum;
    logic signed [RSSI_W-1:0]     show_rssi_min;
    logic signed [RSSI_W-1:0]     show_rssi_max;

    // output register
    logic                         out_valid_reg;
    logic                         out_accepted_reg;
    logic [KIND_W-1:0]            out_kind_reg;
    logic [COUNT_BITS-1:0]        out_packets_reg;
    logic [LOST_W-1:0]            out_lost_reg;
    logic [BYTES_W-1:0]           out_bytes_reg;
    logic [TIME_BITS-1:0]         out_duration_reg;
    logic [TIME_BITS-1:0]         out_jitter_reg;
    logic [TIME_BITS-1:0]         out_latency_reg;
    logic signed [RSSI_W-1:0]     out_low_reg;
    logic signed [RSSI_W-1:0]     out_high_reg;
    logic signed [RSSI_SUM_W-1:0] out_total_reg;

    logic                         take;

    assign pop_ready = !out_valid_reg || report_ch.ready;
    assign take      = pop_valid && pop_ready;

    assign jitter_wide  = {1'b0, jitter_reg} + {1'b0, pop_cmd.jitter_inc};
    assign latency_wide = {1'b0, latency_reg} + {1'b0, pop_cmd.latency_inc};
    assign lost_wide    = {1'b0, lost_reg} + (LOST_W + 1)'(pop_cmd.gap);
    assign bytes_wide   = {1'b0, bytes_reg} + (BYTES_W + 1)'(frame_bytes);
    assign rssi_wide    = {rssi_sum_reg[RSSI_SUM_W-1], rssi_sum_reg}
                        + {{(RSSI_SUM_W + 1 - RSSI_W){pop_cmd.rssi[RSSI_W-1]}}, pop_cmd.rssi};

    assign jitter_upd  = jitter_wide[TIME_BITS] ? '1 : jitter_wide[TIME_BITS-1:0];
    assign latency_upd = latency_wide[TIME_BITS] ? '1 : latency_wide[TIME_BITS-1:0];
    assign lost_upd    = lost_wide[LOST_W] ? '1 : lost_wide[LOST_W-1:0];
    assign bytes_upd   = bytes_wide[BYTES_W] ? '1 : bytes_wide[BYTES_W-1:0];

    // overflow when the two top bits of the widened sum disagree
    always_comb
    begin
        if (rssi_wide[RSSI_SUM_W] != rssi_wide[RSSI_SUM_W-1])
        begin
            rssi_sum_upd = rssi_wide[RSSI_SUM_W] ? RSSI_SUM_MIN : RSSI_SUM_MAX;
        end
        else
        begin
            rssi_sum_upd = rssi_wide[RSSI_SUM_W-1:0];
        end
    end

    assign rssi_min_upd = ($signed(pop_cmd.rssi) < rssi_min_reg) ? pop_cmd.rssi : rssi_min_reg;
    assign rssi_max_upd = ($signed(pop_cmd.rssi) > rssi_max_reg) ? pop_cmd.rssi : rssi_max_reg;

    always_comb
    begin
        show_jitter   = jitter_reg;
        show_latency  = latency_reg;
        show_lost     = lost_reg;
        show_bytes    = bytes_reg;
        show_rssi_sum = rssi_sum_reg;
        show_rssi_min = rssi_min_reg;
        show_rssi_max = rssi_max_reg;

        jitter_next   = jitter_reg;
        latency_next  = latency_reg;
        lost_next     = lost_reg;
        bytes_next    = bytes_reg;
        rssi_sum_next = rssi_sum_reg;
        rssi_min_next = rssi_min_reg;
        rssi_max_next = rssi_max_reg;

        unique case (pop_cmd.kind)
            CMD_CLEAR:
            begin
                show_jitter   = '0;
                show_latency  = '0;
                show_lost     = '0;
                show_bytes    = '0;
                show_rssi_sum = '0;
                show_rssi_min = RSSI_MIN_RESET;
                show_rssi_max = RSSI_MAX_RESET;
            end
            CMD_PACKET:
            begin
                show_jitter   = jitter_upd;
                show_latency  = latency_upd;
                show_lost     = lost_upd;
                show_bytes    = bytes_upd;
                show_rssi_sum = rssi_sum_upd;
                show_rssi_min = rssi_min_upd;
                show_rssi_max = rssi_max_upd;
            end
            default:
            begin
                show_jitter = jitter_reg;
            end
        endcase

        if (pop_cmd.kind == CMD_CLEAR
            || (pop_cmd.kind == CMD_PACKET && pop_cmd.report_kind == RPT_COMPLETE))
        begin
            // session restarts after the report
            jitter_next   = '0;
            latency_next  = '0;
            lost_next     = '0;
            bytes_next    = '0;
            rssi_sum_next = '0;
            rssi_min_next = RSSI_MIN_RESET;
            rssi_max_next = RSSI_MAX_RESET;
        end
        else if (pop_cmd.kind == CMD_PACKET)
        begin
            jitter_next   = jitter_upd;
            latency_next  = latency_upd;
            lost_next     = lost_upd;
            bytes_next    = bytes_upd;
            rssi_sum_next = rssi_sum_upd;
            rssi_min_next = rssi_min_upd;
            rssi_max_next = rssi_max_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jitter_reg    <= '0;
            latency_reg   <= '0;
            lost_reg      <= '0;
            bytes_reg     <= '0;
            rssi_sum_reg  <= '0;
            rssi_min_reg  <= RSSI_MIN_RESET;
            rssi_max_reg  <= RSSI_MAX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                jitter_reg   <= jitter_next;
                latency_reg  <= latency_next;
                lost_reg     <= lost_next;
                bytes_reg    <= bytes_next;
                rssi_sum_reg <= rssi_sum_next;
                rssi_min_reg <= rssi_min_next;
                rssi_max_reg <= rssi_max_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_accepted_reg <= pop_cmd.accepted;
            out_kind_reg     <= pop_cmd.report_kind;
            out_packets_reg  <= pop_cmd.packets_seen;
            out_duration_reg <= pop_cmd.duration;
            out_lost_reg     <= show_lost;
            out_bytes_reg    <= show_bytes;
            out_jitter_reg   <= show_jitter;
            out_latency_reg  <= show_latency;
            out_low_reg      <= show_rssi_min;
            out_high_reg     <= show_rssi_max;
            out_total_reg    <= show_rssi_sum;
        end
    end

    assign report_ch.valid            = out_valid_reg;
    assign report_ch.accepted         = out_accepted_reg;
    assign report_ch.report_kind      = out_kind_reg;
    assign report_ch.packets_seen     = out_packets_reg;
    assign report_ch.packets_lost     = out_lost_reg;
    assign report_ch.bytes_seen       = out_bytes_reg;
    assign report_ch.duration_us      = out_duration_reg;
    assign report_ch.jitter_total_us  = out_jitter_reg;
    assign report_ch.latency_total_us = out_latency_reg;
    assign report_ch.signal_low       = out_low_reg;
    assign report_ch.signal_high      = out_high_reg;
    assign report_ch.signal_total     = out_total_reg;

endmodule

// ===== design/link_packet_stats_monitor.sv =====
// path: an event transfer writes the queue, then the back end loads the output register,
// and the report is valid from that register
// throughput: one event per cycle while the queue has room; every event yields exactly one report
// the output register and the two-entry queue let events keep flowing while a report waits
// reset (rst_n low, asynchronous): statistics and session cleared, min 0, max -127,
// registers back to target 1000, header 0xAA55, 16 bytes per frame; no clearing pass needed
module link_packet_stats_monitor import lpsm_pkg::*; #(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int SEQ_BITS   = SEQ_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    lpsm_event_if.sink   event_ch,
    lpsm_report_if.source report_ch,
    lpsm_cfg_if.sink     cfg
);

    // one command per event, handed from the front end to the back end
    typedef struct packed {
        cmd_kind_t                kind;          // clear, packet update or plain snapshot
        logic                     accepted;      // frame passed the header check
        report_kind_t             report_kind;   // running, complete or partial
        logic [COUNT_BITS-1:0]    packets_seen;  // packet count after this event
        logic [TIME_BITS-1:0]     duration;      // now minus session start
        logic [TIME_BITS-1:0]     jitter_inc;    // zero for the first packet
        logic [TIME_BITS-1:0]     latency_inc;   // zero when no sender timestamp
        logic [SEQ_BITS-1:0]      gap;           // positive sequence gap or zero
        logic signed [RSSI_W-1:0] rssi;
    } cmd_t;

    // configuration registers: the user writes them only while idle; the block does not check
    logic [TARGET_W-1:0] target_packets_reg;
    logic [HEADER_W-1:0] header_magic_reg;
    logic [FBYTES_W-1:0] frame_bytes_reg;

    // front to queue
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;

    // queue to back
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    // register writes are always taken; unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_packets_reg <= TARGET_RESET;
            header_magic_reg   <= MAGIC_RESET;
            frame_bytes_reg    <= FBYTES_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TARGET: target_packets_reg <= cfg.data[TARGET_W-1:0];
                CFG_MAGIC:  header_magic_reg   <= cfg.data[HEADER_W-1:0];
                CFG_FBYTES: frame_bytes_reg    <= cfg.data[FBYTES_W-1:0];
                default:    target_packets_reg <= target_packets_reg;
            endcase
        end
    end

    // front end: header check, session clock, arrival and sequence tracking,
    // packet count and the end-of-session decision
    lpsm_front #(
        .TIME_BITS  (TIME_BITS),
        .SEQ_BITS   (SEQ_BITS),
        .COUNT_BITS (COUNT_BITS),
        .cmd_t      (cmd_t)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .event_ch       (event_ch),
        .target_packets (target_packets_reg),
        .header_magic   (header_magic_reg),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_cmd       (push_cmd)
    );

    // short queue so a stalled report does not stop event intake at once
    lpsm_fifo #(
        .DEPTH   (FIFO_DEPTH),
        .entry_t (cmd_t)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_cmd)
    );

    // back end: saturating sums, signal min/max and the report register
    lpsm_back #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS),
        .cmd_t      (cmd_t)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_cmd     (pop_cmd),
        .frame_bytes (frame_bytes_reg),
        .report_ch   (report_ch)
    );

endmodule

// ===== design/lpsm_checker.sv =====
// lpsm_checker: port-level assertions on the report channel of the monitor
// depends on lpsm_pkg; bound to link_packet_stats_monitor below
module lpsm_checker import lpsm_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  accepted,
    input logic [KIND_W-1:0]     report_kind,
    input logic [COUNT_BITS-1:0] packets_seen,
    input logic [LOST_W-1:0]     packets_lost,
    input logic [RSSI_W-1:0]     signal_low,
    input logic [RSSI_W-1:0]     signal_high
);

    // a stalled report keeps its kind, packet count and loss count
    a_report_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(report_kind)
            && $stable(packets_seen) && $stable(packets_lost))
        else $error("report changed while stalled");

    // only an accepted packet can complete a session
    a_complete_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind == RPT_COMPLETE |-> accepted && packets_seen != '0)
        else $error("complete report without an accepted packet");

    // a partial report comes from an end-session event after some packets
    a_partial_has_packets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind == RPT_PARTIAL |-> !accepted && packets_seen != '0)
        else $error("partial report with no packets");

    // once a packet is in, the signal range is ordered
    a_signal_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packets_seen != '0 |-> $signed(signal_low) <= $signed(signal_high))
        else $error("signal minimum above maximum");

endmodule

bind link_packet_stats_monitor lpsm_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_lpsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (report_ch.valid),
    .out_ready    (report_ch.ready),
    .accepted     (report_ch.accepted),
    .report_kind  (report_ch.report_kind),
    .packets_seen (report_ch.packets_seen),
    .packets_lost (report_ch.packets_lost),
    .signal_low   (report_ch.signal_low),
    .signal_high  (report_ch.signal_high)
);

// ===== tb/lpsm_stats_checker.sv =====
// lpsm_stats_checker: watches the event, report and register channels of the link
// statistics monitor, predicts every report and compares it field by field
// depends on lpsm_pkg and lpsm_ifs
module lpsm_stats_checker import lpsm_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    lpsm_event_if   ev,
    lpsm_report_if  rp,
    lpsm_cfg_if     cfg,
    output int      fail_count,
    output int      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW = TIME_BITS_DEF;
    localparam int SW = SEQ_BITS_DEF;
    localparam int CW = COUNT_BITS_DEF;
    localparam logic [63:0] TIME_CAP  = (64'd1 << TW) - 1;
    localparam logic [63:0] LOST_CAP  = (64'd1 << LOST_W) - 1;
    localparam logic [63:0] BYTES_CAP = (64'd1 << BYTES_W) - 1;
    localparam int SIGNAL_SUM_MAX = (1 << (RSSI_SUM_W - 1)) - 1;
    localparam int SIGNAL_SUM_MIN = -(1 << (RSSI_SUM_W - 1));

    typedef struct packed {
        logic                         accepted;
        report_kind_t                 kind;
        logic [CW-1:0]                seen;
        logic [LOST_W-1:0]            lost;
        logic [BYTES_W-1:0]           bytes;
        logic [TW-1:0]                duration;
        logic [TW-1:0]                jitter;
        logic [TW-1:0]                latency;
        logic signed [RSSI_W-1:0]     low;
        logic signed [RSSI_W-1:0]     high;
        logic signed [RSSI_SUM_W-1:0] total;
    } link_report_t;

    // register copies
    logic [TARGET_W-1:0] target_reg;
    logic [HEADER_W-1:0] magic_reg;
    logic [FBYTES_W-1:0] fbytes_reg;

    // session statistics
    logic [TW-1:0]      start_us;
    logic [TW-1:0]      arrival_prev_us;
    logic [SW-1:0]      seq_prev;
    logic [CW-1:0]      pkt_count;
    logic [LOST_W-1:0]  lost_acc;
    logic [BYTES_W-1:0] byte_acc;
    logic [TW-1:0]      jitter_acc;
    logic [TW-1:0]      latency_acc;
    int                 signal_acc;
    int                 signal_lo;
    int                 signal_hi;

    link_report_t expected_reports[$];
    int           reports_checked;

    function automatic logic [63:0] sat_sum(input logic [63:0] a, b, cap);
        return (b > cap - a) ? cap : a + b;
    endfunction

    function automatic logic [63:0] span_us(input logic [63:0] a, b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function void restart_session(input logic [TW-1:0] now);
        start_us        = now;
        arrival_prev_us = '0;
        seq_prev        = '0;
        pkt_count       = '0;
        lost_acc        = '0;
        byte_acc        = '0;
        jitter_acc      = '0;
        latency_acc     = '0;
        signal_acc      = 0;
        signal_lo       = int'(RSSI_MIN_RESET);
        signal_hi       = int'(RSSI_MAX_RESET);
    endfunction

    function link_report_t snapshot(input logic acc, input report_kind_t kind,
                                    input logic [TW-1:0] now);
        link_report_t r;
        r.accepted = acc;
        r.kind     = kind;
        r.seen     = pkt_count;
        r.lost     = lost_acc;
        r.bytes    = byte_acc;
        r.duration = now - start_us;
        r.jitter   = jitter_acc;
        r.latency  = latency_acc;
        r.low      = signal_lo[RSSI_W-1:0];
        r.high     = signal_hi[RSSI_W-1:0];
        r.total    = signal_acc[RSSI_SUM_W-1:0];
        return r;
    endfunction

    function link_report_t predict_report(input logic [OPCODE_W-1:0] op,
                                          input logic [TW-1:0] now,
                                          input logic [HEADER_W-1:0] hdr,
                                          input logic [SW-1:0] seq,
                                          input logic [TW-1:0] sent,
                                          input logic signed [RSSI_W-1:0] dbm);
        link_report_t r;
        int gap;
        int level;
        level = int'(dbm);
        if (op == OP_START)
        begin
            restart_session(now);
            return snapshot(1'b0, RPT_RUNNING, now);
        end
        if (op == OP_END)
        begin
            if (pkt_count != 0)
                return snapshot(1'b0, RPT_PARTIAL, now);
            return snapshot(1'b0, RPT_RUNNING, now);
        end
        // unused opcode or foreign frame header leaves the session alone
        if (op != OP_PACKET || hdr != magic_reg)
            return snapshot(1'b0, RPT_RUNNING, now);

        if (pkt_count != 0)
            jitter_acc = TW'(sat_sum(64'(jitter_acc), span_us(64'(now), 64'(arrival_prev_us)),
                                     TIME_CAP));
        arrival_prev_us = now;
        if (sent != 0)
            latency_acc = TW'(sat_sum(64'(latency_acc), span_us(64'(now), 64'(sent)),
                                      TIME_CAP));
        if (pkt_count != 0)
        begin
            gap = int'(seq) - int'(seq_prev) - 1;
            if (gap > 0)
                lost_acc = LOST_W'(sat_sum(64'(lost_acc), 64'(gap), LOST_CAP));
        end
        seq_prev = seq;

        signal_acc = signal_acc + level;
        if (signal_acc > SIGNAL_SUM_MAX)
            signal_acc = SIGNAL_SUM_MAX;
        if (signal_acc < SIGNAL_SUM_MIN)
            signal_acc = SIGNAL_SUM_MIN;
        if (level < signal_lo)
            signal_lo = level;
        if (level > signal_hi)
            signal_hi = level;

        if (pkt_count != '1)
            pkt_count = pkt_count + 1'b1;
        byte_acc = BYTES_W'(sat_sum(64'(byte_acc), 64'(fbytes_reg), BYTES_CAP));

        if (pkt_count >= target_reg)
        begin
            r = snapshot(1'b1, RPT_COMPLETE, now);
            restart_session(now);
            return r;
        end
        return snapshot(1'b1, RPT_RUNNING, now);
    endfunction

    task automatic log_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got_v, want_v);
        if (got_v !== want_v)
            log_mismatch($sformatf("report %0d %s is %0h, expected %0h",
                                   reports_checked, name, got_v, want_v));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        link_report_t want;
        if (!rst_n)
        begin
            target_reg = TARGET_RESET;
            magic_reg  = MAGIC_RESET;
            fbytes_reg = FBYTES_RESET;
            restart_session('0);
            expected_reports.delete();
            reports_checked = 0;
            fail_count      = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_TARGET: target_reg = cfg.data[TARGET_W-1:0];
                    CFG_MAGIC:  magic_reg  = cfg.data[HEADER_W-1:0];
                    CFG_FBYTES: fbytes_reg = cfg.data[FBYTES_W-1:0];
                    default: ;
                endcase
            end
            if (ev.valid && ev.ready)
                expected_reports.push_back(predict_report(ev.opcode, ev.now_us,
                    ev.frame_header, ev.sequence_req, ev.sent_time_us, ev.signal_dbm));
            if (rp.valid && rp.ready)
            begin
                if (expected_reports.size() == 0)
                    log_mismatch($sformatf("report %0d arrived with nothing expected",
                                           reports_checked));
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("accepted", 64'(rp.accepted), 64'(want.accepted));
                    check_field("report_kind", 64'(rp.report_kind), 64'(want.kind));
                    check_field("packets_seen", 64'(rp.packets_seen), 64'(want.seen));
                    check_field("packets_lost", 64'(rp.packets_lost), 64'(want.lost));
                    check_field("bytes_seen", 64'(rp.bytes_seen), 64'(want.bytes));
                    check_field("duration_us", 64'(rp.duration_us), 64'(want.duration));
                    check_field("jitter_total_us", 64'(rp.jitter_total_us),
                                64'(want.jitter));
                    check_field("latency_total_us", 64'(rp.latency_total_us),
                                64'(want.latency));
                    check_field("signal_low", 64'(rp.signal_low), 64'(want.low));
                    check_field("signal_high", 64'(rp.signal_high), 64'(want.high));
                    check_field("signal_total", 64'(rp.signal_total), 64'(want.total));
                end
                reports_checked++;
            end
        end
        pending = expected_reports.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus and verdict for the link statistics monitor
// drives events and register writes, stalls the report side, and leaves checking to
// lpsm_stats_checker; depends on lpsm_pkg, lpsm_ifs and the monitor itself
module tb_top import lpsm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 120000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 205;
    localparam int HOLD_CYCLES = 48;

    // the opcode the block does not define, still a legal field value
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [47:0]         TIME_TOP  = 48'hFFFF_FFFF_FFFF;

    logic clk;
    logic rst_n;

    lpsm_event_if  ev ();
    lpsm_report_if rp ();
    lpsm_cfg_if    cfg_ch ();

    int fail_count;
    int pending;
    int cycle_count = 0;

    // idling knobs, percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;
    // asks the report side for one long hold-off
    bit hold_req  = 1'b0;

    // stimulus-side view of the session, used to shape well-formed traffic
    logic [HEADER_W-1:0] magic_now;
    logic [47:0]         clock_us;
    logic [15:0]         seq_now;

    // per-phase register settings; the later phases draw magic and frame size at random
    logic [TARGET_W-1:0] phase_target [PHASES] =
        '{16'd1, 16'd0, 16'd5, 16'hFFFF, 16'd1000, 16'd3, 16'd17, 16'd2};
    logic [HEADER_W-1:0] phase_magic [PHASES] =
        '{16'h0000, 16'hFFFF, 16'hAA55, 16'h0001, 16'h8000, 16'h0000, 16'h0000, 16'h0000};
    logic [FBYTES_W-1:0] phase_fbytes [PHASES] =
        '{8'd1, 8'd255, 8'd16, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0};

    link_packet_stats_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .event_ch  (ev),
        .report_ch (rp),
        .cfg       (cfg_ch)
    );

    lpsm_stats_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .ev         (ev),
        .rp         (rp),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // watchdog: a hung handshake or a lost report ends up here
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // report side: random stalls, plus a long hold-off on request so the
    // queue and output register fill and the event side backs up
    initial
    begin
        int hold_left;
        hold_left = 0;
        rp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rp.ready <= 1'b0;
            end
            else
                rp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one event transfer; entered and left at a falling edge, valid stays high
    // between back-to-back events and is only lowered for an idle gap
    task automatic send_event(input logic [OPCODE_W-1:0] op, input logic [47:0] now,
                              input logic [HEADER_W-1:0] hdr, input logic [15:0] seq,
                              input logic [47:0] sent, input logic signed [RSSI_W-1:0] dbm);
        while ($urandom_range(99) < idle_pct)
        begin
            ev.valid <= 1'b0;
            @(negedge clk);
        end
        ev.valid        <= 1'b1;
        ev.opcode       <= op;
        ev.now_us       <= now;
        ev.frame_header <= hdr;
        ev.sequence_req <= seq;
        ev.sent_time_us <= sent;
        ev.signal_dbm   <= dbm;
        @(posedge clk);
        while (!ev.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // one register write transfer, valid left high for a following write
    task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_config(input logic [TARGET_W-1:0] target,
                               input logic [HEADER_W-1:0] magic,
                               input logic [FBYTES_W-1:0] fbytes);
        put_reg(CFG_TARGET, target);
        put_reg(CFG_MAGIC, magic);
        // upper data bits are junk the register must drop
        put_reg(CFG_FBYTES, {8'($urandom), fbytes});
        cfg_ch.valid <= 1'b0;
        magic_now = magic;
    endtask

    // stop offering events and wait until every report has come back
    task automatic drain_reports();
        ev.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // mostly well-formed traffic: matching headers, time moving forward,
    // sequence numbers counting up with the odd gap; the rest is noise
    task automatic send_random_item();
        logic [OPCODE_W-1:0]      op;
        logic [HEADER_W-1:0]      hdr;
        logic [47:0]              sent;
        logic signed [RSSI_W-1:0] dbm;
        int                       pick;
        pick = $urandom_range(99);
        if (pick < 4)
            op = OP_START;
        else if (pick < 8)
            op = OP_END;
        else if (pick < 10)
            op = OP_UNUSED;
        else
            op = OP_PACKET;

        // arrival time: usual small steps, sometimes backwards, rarely anywhere
        pick = $urandom_range(99);
        if (pick < 6)
            clock_us = {16'($urandom), 32'($urandom)};
        else if (pick < 12)
            clock_us = clock_us - $urandom_range(500);
        else
            clock_us = clock_us + $urandom_range(1, 3000);

        pick = $urandom_range(99);
        hdr = (pick < 88) ? magic_now : 16'($urandom);

        // sequence: in order, forward gaps, repeats or steps back, random jumps
        pick = $urandom_range(99);
        if (pick < 78)
            seq_now = seq_now + 1'b1;
        else if (pick < 88)
            seq_now = seq_now + 16'($urandom_range(2, 40));
        else if (pick < 94)
            seq_now = seq_now - 16'($urandom_range(30));
        else
            seq_now = 16'($urandom);

        // sender timestamp: absent, garbage, or shortly before arrival
        pick = $urandom_range(99);
        if (pick < 15)
            sent = '0;
        else if (pick < 25)
            sent = {16'($urandom), 32'($urandom)};
        else
            sent = clock_us - $urandom_range(2000);

        dbm = 8'($urandom_range(255));
        send_event(op, clock_us, hdr, seq_now, sent, dbm);
    endtask

    initial
    begin
        logic [HEADER_W-1:0] magic;
        logic [FBYTES_W-1:0] fbytes;

        // every input known from time zero
        ev.valid        = 1'b0;
        ev.opcode       = OP_PACKET;
        ev.now_us       = '0;
        ev.frame_header = '0;
        ev.sequence_req = '0;
        ev.sent_time_us = '0;
        ev.signal_dbm   = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_TARGET;
        cfg_ch.data     = '0;
        magic_now       = MAGIC_RESET;
        clock_us        = '0;
        seq_now         = '0;
        rst_n           = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset register values
        // end session with nothing received, then the unused opcode
        send_event(OP_END, 48'd7, MAGIC_RESET, 16'd0, 48'd0, 8'sd0);
        send_event(OP_UNUSED, 48'd8, MAGIC_RESET, 16'd1, 48'd3, 8'sd5);
        // foreign header is dropped
        send_event(OP_PACKET, 48'd100, ~MAGIC_RESET, 16'd9, 48'd90, -8'sd40);
        // first packet: no jitter, no loss, no timestamp, weakest signal
        send_event(OP_PACKET, 48'd100, MAGIC_RESET, 16'd10, 48'd0, 8'sh80);
        // arrival earlier than the last one, strongest signal
        send_event(OP_PACKET, 48'd90, MAGIC_RESET, 16'd11, 48'd50, 8'sd127);
        // forward gap, time and timestamp at their ceiling
        send_event(OP_PACKET, TIME_TOP, MAGIC_RESET, 16'd20, TIME_TOP, -8'sd1);
        // sequence steps back; jitter and latency sums saturate
        send_event(OP_PACKET, 48'd0, MAGIC_RESET, 16'd5, TIME_TOP, 8'sd0);
        // a large forward gap, then sequence wraps to zero without loss
        send_event(OP_PACKET, 48'd1, MAGIC_RESET, 16'hFFFF, 48'd1, 8'sd1);
        send_event(OP_PACKET, 48'd2, MAGIC_RESET, 16'h0000, 48'h8000_0000_0000, -8'sd90);
        // end session twice: the partial report repeats since nothing is cleared
        send_event(OP_END, 48'd50, MAGIC_RESET, 16'd0, 48'd0, 8'sd0);
        send_event(OP_END, 48'd60, 16'h0000, 16'hFFFF, TIME_TOP, 8'sh80);
        // new session, then events stamped before its start
        send_event(OP_START, 48'd1000, 16'hFFFF, 16'hFFFF, TIME_TOP, 8'sd127);
        send_event(OP_END, 48'd500, MAGIC_RESET, 16'd0, 48'd0, 8'sd0);
        send_event(OP_PACKET, 48'd400, 16'h0000, 16'd3, 48'd10, 8'sd3);
        send_event(OP_PACKET, 48'd400, 16'hFFFF, 16'd3, 48'd10, 8'sd3);
        send_event(OP_PACKET, 48'd400, MAGIC_RESET, 16'd0, 48'd390, -8'sd60);
        send_event(OP_PACKET, 48'd410, MAGIC_RESET, 16'd1, 48'd405, -8'sd61);
        send_event(OP_END, 48'd300, MAGIC_RESET, 16'd0, 48'd0, 8'sd0);
        send_event(OP_UNUSED, TIME_TOP, 16'hFFFF, 16'hFFFF, TIME_TOP, -8'sd1);
        send_event(OP_START, 48'd0, 16'h0000, 16'h0000, 48'd0, 8'sd0);
        drain_reports();

        // random phases: each one reprograms the registers while the block is idle
        // and cycles through the idling styles
        for (int p = 0; p < PHASES; p++)
        begin
            magic  = (p >= 5) ? 16'($urandom) : phase_magic[p];
            fbytes = (p >= 5) ? 8'($urandom_range(1, 255)) : phase_fbytes[p];
            load_config(phase_target[p], magic, fbytes);
            clock_us = {16'($urandom), 32'($urandom)};
            seq_now  = 16'($urandom);
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    // back-pressure: receiver holds off while events keep coming
                    hold_req  = 1'b1;
                end
                1:
                begin
                    idle_pct  = 55;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 55;
                end
                default:
                begin
                    idle_pct  = 19;
                    stall_pct = 19;
                end
            endcase
            repeat (PHASE_ITEMS)
                send_random_item();
            drain_reports();
        end

        // let anything stray come out before the verdict
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
